// ===== rtl/core/sha256_stream_hasher_assert.svh =====
// Assertion macros for the hasher.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned RoundCount = 64;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_item;
  } in_word_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } out_word_t;

  // Control from the byte sequencer to the round unit.
  typedef struct packed {
    logic start;
  } rnd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
  logic               valid;
  logic               ready;
  sha_pkg::in_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sha_out_if;
  logic               valid;
  logic               ready;
  sha_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sha_rounds.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Compression engine. Schedule window lives in a 16x32 memory with registered
// read; rounds 16-63 read W[t-15], W[t-2], W[t-7], W[t-16] in turn, write
// W[t] back and update the working variables; rounds 0-15 read only W[t].
module sha_rounds (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // word writes into the schedule memory
  input  wire logic              wr_en_i,
  input  wire logic [3:0]        wr_addr_i,
  input  wire sha_pkg::word_t    wr_data_i,
  input  wire sha_pkg::rnd_req_t req_i,
  input  wire logic              clear_i,
  input  wire logic [2:0]        rd_idx_i,
  output sha_pkg::word_t         hash_o,
  output sha_pkg::rnd_sts_t      sts_o
);

  typedef enum logic [2:0] {
    RIdle, RRd15, RRd2, RRd7, RRd16, RCalc, RFin
  } rstate_e;

  sha_pkg::word_t mem [16];
  sha_pkg::word_t rd_q;
  logic [3:0]     raddr;

  rstate_e        state_q;
  logic [5:0]     t_q;
  sha_pkg::word_t x15_q, x2_q, x7_q;
  sha_pkg::word_t v_q [8];
  sha_pkg::word_t h_q [8];
  logic [2:0]     fin_q;

  logic           rnd_wr;
  sha_pkg::word_t w_new;
  sha_pkg::word_t w_cur;
  sha_pkg::word_t g0, g1, s0, s1, ch, mj, t1, t2;

  always_comb begin
    raddr = t_q[3:0];
    case (state_q)
      RRd15:   raddr = t_q[3:0] - 4'd15;
      RRd2:    raddr = t_q[3:0] - 4'd2;
      RRd7:    raddr = t_q[3:0] - 4'd7;
      default: raddr = t_q[3:0];
    endcase
  end

  always_comb begin
    g0 = sha_pkg::rotr(x15_q, 7) ^ sha_pkg::rotr(x15_q, 18) ^ (x15_q >> 3);
    g1 = sha_pkg::rotr(x2_q, 17) ^ sha_pkg::rotr(x2_q, 19) ^ (x2_q >> 10);
    w_new = rd_q + g0 + x7_q + g1;
    w_cur = (t_q >= 6'd16) ? w_new : rd_q;
    s1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + sha_pkg::RoundK[t_q] + w_cur;
    s0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
    rnd_wr = (state_q == RCalc) && (t_q >= 6'd16);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end else if (rnd_wr) begin
      mem[t_q[3:0]] <= w_new;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RIdle;
      t_q     <= '0;
      fin_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
    end else begin
      case (state_q)
        RIdle: begin
          if (clear_i) begin
            for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
          end
          if (req_i.start) begin
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            t_q     <= '0;
            state_q <= RRd16;
          end
        end
        RRd15: state_q <= RRd2;
        RRd2: begin
          x15_q   <= rd_q;
          state_q <= RRd7;
        end
        RRd7: begin
          x2_q    <= rd_q;
          state_q <= RRd16;
        end
        RRd16: begin
          if (t_q >= 6'd16) x7_q <= rd_q;
          state_q <= RCalc;
        end
        RCalc: begin
          for (int i = 1; i < 8; i++) begin
            if (i != 4) v_q[i] <= v_q[i-1];
          end
          v_q[4] <= v_q[3] + t1;
          v_q[0] <= t1 + t2;
          t_q    <= t_q + 6'd1;
          if (t_q == 6'(sha_pkg::RoundCount - 1)) begin
            fin_q   <= '0;
            state_q <= RFin;
          end else if (t_q >= 6'd15) begin
            state_q <= RRd15;
          end else begin
            state_q <= RRd16;
          end
        end
        RFin: begin
          h_q[fin_q] <= h_q[fin_q] + v_q[fin_q];
          fin_q      <= fin_q + 3'd1;
          if (fin_q == 3'd7) state_q <= RIdle;
        end
        default: state_q <= RIdle;
      endcase
    end
  end

  assign hash_o    = h_q[rd_idx_i];
  assign sts_o.busy = (state_q != RIdle);
  assign sts_o.done = (state_q == RFin) && (fin_q == 3'd7);

endmodule
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload
// in_if   | in  | data_byte[8], byte_present, final_item
// out_if  | out | digest_word[32], word_index[3], last_word
//
// A byte that fills no block passes accept (SIdle), store (SByte) and next-step
// check (SPad). A full block runs 64 rounds in the round unit: rounds 0-15 pass
// RRd16 and RCalc, rounds 16-63 pass RRd15, RRd2, RRd7, RRd16 and RCalc (schedule
// memory reads), then RFin adds the working variables into the hash. A final
// word pads up to two blocks, then sends eight words, one per cycle when the
// sink is ready. Reset restores the initial hash; the schedule memory needs no
// clear. Input stalls while a block compresses or the digest sends.
module sha256_stream_hasher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);

  typedef enum logic [2:0] {
    SIdle, SByte, SWait, SPad, SOut, SClr
  } state_e;

  state_e         state_q;
  logic [5:0]     cnt_q;
  logic [63:0]    len_q;
  logic [63:0]    plen_q;
  logic           fin_q;
  logic           padded_q;
  logic [7:0]     byte_q;
  logic [3:0]     pad_cnt_q;
  sha_pkg::word_t acc_q;
  logic [2:0]     oidx_q;
  logic           ovalid_q;

  logic              wr_en;
  sha_pkg::rnd_req_t req;
  sha_pkg::rnd_sts_t sts;
  sha_pkg::word_t    hash;
  sha_pkg::word_t    acc_d;
  logic              clear;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    acc_d = {byte_q, 24'd0};
      2'd1:    acc_d = {acc_q[31:24], byte_q, 16'd0};
      2'd2:    acc_d = {acc_q[31:16], byte_q, 8'd0};
      default: acc_d = {acc_q[31:8], byte_q};
    endcase
  end

  assign wr_en     = (state_q == SByte) && (cnt_q[1:0] == 2'd3);
  assign req.start = (state_q == SByte) && (cnt_q == 6'd63);
  assign clear     = (state_q == SClr);

  sha_rounds u_rounds (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[5:2]),
    .wr_data_i (acc_d),
    .req_i     (req),
    .clear_i   (clear),
    .rd_idx_i  (oidx_q),
    .hash_o    (hash),
    .sts_o     (sts)
  );

  assign in_if.ready = (state_q == SIdle);
  assign out_if.valid = ovalid_q;
  assign out_if.payload.digest_word = hash;
  assign out_if.payload.word_index  = oidx_q;
  assign out_if.payload.last_word   = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      len_q     <= '0;
      plen_q    <= '0;
      fin_q     <= 1'b0;
      padded_q  <= 1'b0;
      pad_cnt_q <= '0;
      oidx_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_if.valid) begin
            fin_q    <= in_if.payload.final_item;
            padded_q <= 1'b0;
            plen_q   <= len_q + (in_if.payload.byte_present ? 64'd8 : 64'd0);
            if (in_if.payload.byte_present) begin
              byte_q  <= in_if.payload.data_byte;
              len_q   <= len_q + 64'd8;
              state_q <= SByte;
            end else if (in_if.payload.final_item) begin
              byte_q   <= 8'h80;
              padded_q <= 1'b1;
              state_q  <= SByte;
            end
          end
        end
        SByte: begin
          acc_q   <= acc_d;
          cnt_q   <= cnt_q + 6'd1;
          state_q <= (cnt_q == 6'd63) ? SWait : SPad;
        end
        SWait: begin
          if (!sts.busy) state_q <= SPad;
        end
        SPad: begin
          if (!fin_q) begin
            state_q <= SIdle;
          end else if (!padded_q) begin
            byte_q   <= 8'h80;
            padded_q <= 1'b1;
            state_q  <= SByte;
          end else if (cnt_q != 6'd56 && pad_cnt_q == 4'd0) begin
            byte_q  <= 8'h00;
            state_q <= SByte;
          end else if (pad_cnt_q != 4'd8) begin
            byte_q    <= plen_q[63 - 8*pad_cnt_q[2:0] -: 8];
            pad_cnt_q <= pad_cnt_q + 4'd1;
            state_q   <= SByte;
          end else begin
            pad_cnt_q <= '0;
            oidx_q    <= '0;
            ovalid_q  <= 1'b1;
            state_q   <= SOut;
          end
        end
        SOut: begin
          if (out_if.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              ovalid_q <= 1'b0;
              state_q  <= SClr;
            end
          end
        end
        SClr: begin
          len_q   <= '0;
          cnt_q   <= '0;
          fin_q   <= 1'b0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `include "sha256_stream_hasher_assert.svh"

  `SHA_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, sts.busy, !in_if.ready, "accept while busy")
  `SHA_ASSERT_IMP(a_out_idle, clk_i, rst_ni, out_if.valid, !sts.busy && !in_if.ready, "output while busy")
  `SHA_ASSERT_NXT(a_last_done, clk_i, rst_ni, out_if.valid && out_if.ready && out_if.payload.last_word, !out_if.valid, "output after last")
  `SHA_ASSERT_NXT(a_done_idle, clk_i, rst_ni, sts.done, !sts.busy, "round unit busy after done")

endmodule
`default_nettype wire

// ===== sim/sha256_stream_hasher_checker.sv =====
`timescale 1ns / 1ps
module sha256_stream_hasher_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_mon,
  sha_out_if.source out_mon,
  output int        fail_count_o
);

  sha_pkg::word_t     hash_st [8];
  sha_pkg::word_t     sched [16];
  logic [5:0]         blk_cnt;
  logic [63:0]        bit_len;
  sha_pkg::out_word_t digest_q [$];

  function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    sha_pkg::word_t v [8];
    sha_pkg::word_t s1, ch, t1, s0, mj, g0, g1, x15, x2;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x15 = sched[(t - 15) & 15];
        x2  = sched[(t - 2) & 15];
        g0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
        g1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
        sched[t & 15] = sched[t & 15] + g0 + sched[(t - 7) & 15] + g1;
      end
      s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sha_pkg::RoundK[t] + sched[t & 15];
      s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + s0 + mj;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic load_byte(logic [7:0] b);
    int sh;
    sh = (3 - blk_cnt[1:0]) * 8;
    if (blk_cnt[1:0] == 0) sched[blk_cnt[5:2]] = sha_pkg::word_t'(b) << sh;
    else sched[blk_cnt[5:2]] |= sha_pkg::word_t'(b) << sh;
    blk_cnt = blk_cnt + 6'd1;
    if (blk_cnt == 0) compress();
  endtask

  task automatic hash_word(sha_pkg::in_word_t w);
    logic [63:0] len;
    sha_pkg::out_word_t o;
    if (w.byte_present) begin
      load_byte(w.data_byte);
      bit_len += 64'd8;
    end
    if (w.final_item) begin
      len = bit_len;
      load_byte(8'h80);
      while (blk_cnt != 6'd56) load_byte(8'h00);
      for (int k = 7; k >= 0; k--) load_byte(len[8*k +: 8]);
      for (int k = 0; k < 8; k++) begin
        o.digest_word = hash_st[k];
        o.word_index = 3'(k);
        o.last_word = (k == 7);
        digest_q.push_back(o);
      end
      for (int i = 0; i < 8; i++) hash_st[i] = sha_pkg::InitHash[i];
      blk_cnt = '0;
      bit_len = '0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < 8; i++) hash_st[i] = sha_pkg::InitHash[i];
    blk_cnt = '0;
    bit_len = '0;
  end

  always @(posedge clk_i) begin
    sha_pkg::out_word_t exp, got;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) hash_word(in_mon.payload);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (digest_q.size() == 0) report("unexpected word", got.digest_word, 0);
        else begin
          exp = digest_q.pop_front();
          if (got.digest_word !== exp.digest_word)
            report("digest_word", got.digest_word, exp.digest_word);
          if (got.word_index !== exp.word_index)
            report("word_index", 32'(got.word_index), 32'(exp.word_index));
          if (got.last_word !== exp.last_word)
            report("last_word", 32'(got.last_word), 32'(exp.last_word));
        end
      end
    end
  end

  function automatic int pending();
    return digest_q.size();
  endfunction
endmodule

// ===== sim/sha256_stream_hasher_test.sv =====
`timescale 1ns / 1ps
module sha256_stream_hasher_test;

  localparam int IdleLimit = 20000;
  localparam int ItemCount = 210;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count;
  int   idle_cycles = 0;
  int   hold_off = 0;
  bit   long_done = 0;
  bit   stim_done = 0;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_stream_hasher uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if));

  sha256_stream_hasher_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_if), .out_mon(out_if),
    .fail_count_o(fail_count)
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  initial begin
    in_if.valid = 0;
    in_if.payload = '0;
    out_if.ready = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;
  end

  // receiver: stall pattern, one long hold-off on the first digest
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 0;
    end else if (!long_done && rst_ni && out_if.valid) begin
      hold_off <= 600;
      long_done <= 1;
      out_if.ready <= 0;
    end else begin
      case ((int'($realtime) / 1200) % 3)
        0: out_if.ready <= 1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_word(logic [7:0] b, logic pres, logic fin);
    sha_pkg::in_word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    w.data_byte = b;
    w.byte_present = pres;
    w.final_item = fin;
    in_if.payload <= w;
    in_if.valid <= 1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_message(int len, int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'($urandom_range(0, 255));
        1: b = 8'h00;
        default: b = 8'hff;
      endcase
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 0, 0);
      send_word(b, 1, (i == len - 1) && (mode != 3));
    end
    if (len == 0 || mode == 3) send_word(8'($urandom_range(0, 255)), 0, 1);
  endtask

  initial begin
    int sent;
    @(posedge rst_ni);
    @(negedge clk_i);
    send_word(8'h00, 0, 1);
    send_word(8'h61, 1, 0); send_word(8'h62, 1, 0); send_word(8'h63, 1, 1);
    send_word(8'hff, 0, 0);
    send_message(1, 1);
    send_message(1, 2);
    send_message(2, 3);
    send_message(8, 0);
    sent = 18;
    while (sent < ItemCount) begin
      int len;
      int mode;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(54, 57);
        2: len = 63 + $urandom_range(0, 2);
        3: len = $urandom_range(118, 121);
        default: len = $urandom_range(4, 40);
      endcase
      if (len > ItemCount - sent) len = ItemCount - sent;
      mode = ($urandom_range(0, 9) == 0) ? 3 : (($urandom_range(0, 7) == 0) ? 2 : 0);
      send_message(len, mode);
      sent += (len == 0 || mode == 3) ? len + 1 : len;
    end
    in_if.valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_stream_if.sv
rtl/core/sha_rounds.sv
rtl/core/sha256_stream_hasher.sv
sim/sha256_stream_hasher_checker.sv
sim/sha256_stream_hasher_test.sv
